### rtl/twb_pkg.sv
// Package for the wrapped tile window builder: coordinate types, sizes,
// register indexes and the start coordinate function.
// Depends on nothing; every other file of the block imports it.
package twb_pkg;

  // Field widths fixed by the interface.
  localparam int POS_W    = 32;
  localparam int ORIGIN_W = 16;
  localparam int SIZE_W   = 11;
  localparam int TILE_W   = 16;
  localparam int ROW_W    = 4;

  // Tile fields carried by one row word.
  localparam int TILE_COLS = 9;

  // Signed tile coordinate: the wrapped start needs 19 bits, one more
  // leaves room for the increments across a window.
  localparam int COORD_W = 20;

  // Depth of the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_WORLD_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WORLD_HEIGHT = 1'd1;

  // Reset value of both size registers.
  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd64;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [SIZE_W-1:0]         size_t;
  typedef logic [TILE_W-1:0]         tile_t;

  // One window job: the column coordinates shared by all rows and the
  // starting row coordinate.
  typedef struct packed {
    coord_t [TILE_COLS-1:0] xs;
    coord_t                 tz;
  } twb_job_t;

  // A job together with its valid flag, as it moves between parts.
  typedef struct packed {
    logic     valid;
    twb_job_t job;
  } twb_job_word_t;

  // Widen a size register into a signed coordinate for comparisons.
  function automatic coord_t size_to_coord(input size_t size);
    return $signed({{(COORD_W - SIZE_W){1'b0}}, size});
  endfunction

  // Start tile along one axis: scale the position down to a tile, move it
  // into the map section, wrap once against the section span and drop the
  // sub-tile bits.
  function automatic coord_t axis_start(input logic signed [POS_W-1:0]    pos,
                                        input logic signed [ORIGIN_W-1:0] origin,
                                        input size_t                      size);
    logic signed [19:0] t_tile;
    logic signed [19:0] t_round;
    logic signed [16:0] t_cell;
    logic signed [16:0] o_sum;
    logic signed [25:0] o_ofs;
    logic signed [26:0] t_rel;
    logic signed [26:0] span;
    logic signed [26:0] t_wrap;
    logic signed [18:0] t_out;
    t_tile  = $signed(pos[31:12]);
    t_round = t_tile[19] ? t_tile + 20'sd7 : t_tile;
    t_cell  = $signed(t_round[19:3]);
    o_sum   = $signed({origin[15], origin}) + 17'sd2;
    o_ofs   = $signed({o_sum, 8'b0, 1'b0}) >>> 1;
    t_rel   = $signed({{10{t_cell[16]}}, t_cell}) - $signed({o_ofs[25], o_ofs});
    span    = $signed({8'b0, size, 8'b0});
    if (t_rel < 27'sd0) begin
      t_wrap = t_rel + span;
    end else if (span < t_rel) begin
      t_wrap = t_rel - span;
    end else begin
      t_wrap = t_rel;
    end
    t_out = $signed(t_wrap[26:8]);
    return $signed({t_out[18], t_out});
  endfunction

endpackage

### rtl/twb_if.sv
// Handshake interfaces for the tile window builder: the position word in
// and the window row word out.
// Depends on twb_pkg.
interface twb_in_if;
  import twb_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [POS_W-1:0]    pos_x;
  logic signed [POS_W-1:0]    pos_z;
  logic signed [ORIGIN_W-1:0] origin_x;
  logic signed [ORIGIN_W-1:0] origin_z;

  modport source (output valid, pos_x, pos_z, origin_x, origin_z, input ready);
  modport sink   (input valid, pos_x, pos_z, origin_x, origin_z, output ready);
endinterface

interface twb_out_if;
  import twb_pkg::*;

  logic             valid;
  logic             ready;
  logic [TILE_W-1:0] tile_0;
  logic [TILE_W-1:0] tile_1;
  logic [TILE_W-1:0] tile_2;
  logic [TILE_W-1:0] tile_3;
  logic [TILE_W-1:0] tile_4;
  logic [TILE_W-1:0] tile_5;
  logic [TILE_W-1:0] tile_6;
  logic [TILE_W-1:0] tile_7;
  logic [TILE_W-1:0] tile_8;
  logic [ROW_W-1:0]  row_number;
  logic              last_row;

  modport source (output valid, tile_0, tile_1, tile_2, tile_3, tile_4, tile_5,
                  tile_6, tile_7, tile_8, row_number, last_row, input ready);
  modport sink   (input valid, tile_0, tile_1, tile_2, tile_3, tile_4, tile_5,
                  tile_6, tile_7, tile_8, row_number, last_row, output ready);
endinterface

### rtl/twb_front.sv
// Front part of the tile window builder: accepts position words, computes
// the wrapped start tile per axis and builds the column coordinates.
// Depends on twb_pkg and twb_if.
module twb_front #(
  parameter int WINDOW_SIZE = 9
) (
  input  logic                  clk,
  input  logic                  rst,
  twb_in_if.sink                items,
  input  twb_pkg::size_t        world_width,
  input  twb_pkg::size_t        world_height,
  input  logic                  queue_full,
  output twb_pkg::twb_job_word_t push_word
);
  import twb_pkg::*;

  localparam int EMIT_N = (WINDOW_SIZE < TILE_COLS) ? WINDOW_SIZE : TILE_COLS;
  localparam logic [ROW_W-1:0] EMIT_LAST = ROW_W'(EMIT_N);

  // Start stage registers.
  logic   stage_valid;
  coord_t stage_tx;
  coord_t stage_tz;

  // Column builder registers.
  logic                   bld_busy;
  logic [ROW_W-1:0]       bld_cnt;
  coord_t                 bld_x;
  coord_t [TILE_COLS-1:0] bld_xs;
  coord_t                 bld_tz;

  logic   bld_done;
  logic   bld_push;
  logic   bld_load;
  coord_t w_coord;
  coord_t x_first;
  coord_t x_step;

  assign w_coord  = size_to_coord(world_width);
  assign bld_done = bld_busy && (bld_cnt == EMIT_LAST);
  assign bld_push = bld_done && !queue_full;
  assign bld_load = stage_valid && (!bld_busy || bld_push);

  // The start stage takes a word whenever it is empty or hands off now.
  assign items.ready = !stage_valid || bld_load;

  // Column wrap: a coordinate at or past the width restarts at zero.
  assign x_first = (stage_tx >= w_coord) ? '0 : stage_tx;
  assign x_step  = (bld_x >= w_coord) ? '0 : bld_x;

  // Start stage valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (items.valid && items.ready) begin
      stage_valid <= 1'b1;
    end else if (bld_load) begin
      stage_valid <= 1'b0;
    end
  end

  // Start stage payload.
  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      stage_tx <= axis_start(items.pos_x, items.origin_x, world_width);
      stage_tz <= axis_start(items.pos_z, items.origin_z, world_height);
    end
  end

  // Column builder control: one column per cycle, the first on load.
  always_ff @(posedge clk) begin
    if (rst) begin
      bld_busy <= 1'b0;
      bld_cnt  <= '0;
    end else if (bld_load) begin
      bld_busy <= 1'b1;
      bld_cnt  <= ROW_W'(1);
    end else if (bld_busy && !bld_done) begin
      bld_cnt <= bld_cnt + ROW_W'(1);
    end else if (bld_push) begin
      bld_busy <= 1'b0;
    end
  end

  // Column builder payload.
  always_ff @(posedge clk) begin
    if (bld_load) begin
      bld_xs[0] <= x_first;
      bld_x     <= x_first + COORD_W'(1);
      bld_tz    <= stage_tz;
    end else if (bld_busy && !bld_done) begin
      bld_xs[bld_cnt] <= x_step;
      bld_x           <= x_step + COORD_W'(1);
    end
  end

  assign push_word.valid   = bld_push;
  assign push_word.job.xs  = bld_xs;
  assign push_word.job.tz  = bld_tz;

endmodule

### rtl/twb_queue.sv
// Short queue of window jobs between the front and back parts.
// Depends on twb_pkg.
module twb_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  twb_pkg::twb_job_word_t push_word,
  output logic                   full,
  output twb_pkg::twb_job_word_t head,
  input  logic                   pop
);
  import twb_pkg::*;

  twb_job_t [QUEUE_DEPTH-1:0] mem;
  logic [QPTR_W-1:0]          wr_ptr;
  logic [QPTR_W-1:0]          rd_ptr;
  logic [QCNT_W-1:0]          count;

  logic do_pop;

  assign do_pop = pop && (count != '0);
  assign full   = (count == QCNT_W'(QUEUE_DEPTH));

  // Pointer and occupancy bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_word.valid) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push_word.valid && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !push_word.valid) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push_word.valid) begin
      mem[wr_ptr] <= push_word.job;
    end
  end

  assign head.valid = (count != '0);
  assign head.job   = mem[rd_ptr];

endmodule

### rtl/twb_back.sv
// Back part of the tile window builder: walks the rows of a window job
// and emits one row word per cycle, while rows.ready is high, through
// an output register. Depends on twb_pkg and twb_if.
module twb_back #(
  parameter int WINDOW_SIZE = 9
) (
  input  logic                   clk,
  input  logic                   rst,
  input  twb_pkg::twb_job_word_t head,
  output logic                   pop,
  input  twb_pkg::size_t         world_width,
  input  twb_pkg::size_t         world_height,
  twb_out_if.source              rows
);
  import twb_pkg::*;

  localparam int EMIT_N = (WINDOW_SIZE < TILE_COLS) ? WINDOW_SIZE : TILE_COLS;
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(EMIT_N - 1);

  // Row walker registers.
  logic                   active;
  logic [ROW_W-1:0]       row;
  coord_t                 z_cur;
  coord_t [TILE_COLS-1:0] xs;

  // Output register.
  logic                   out_valid;
  tile_t [TILE_COLS-1:0]  out_tiles;
  logic [ROW_W-1:0]       out_row;
  logic                   out_last;

  logic                   advance;
  logic                   is_last;
  logic                   load;
  coord_t                 z_row;
  logic [26:0]            product;
  tile_t                  base;
  tile_t [TILE_COLS-1:0]  tiles_next;

  assign advance = active && (!out_valid || rows.ready);
  assign is_last = (row == LAST_ROW);
  assign load    = head.valid && (!active || (advance && is_last));
  assign pop     = load;

  // Row wrap against the height, then the row base tile number.
  assign z_row   = (z_cur >= size_to_coord(world_height)) ? '0 : z_cur;
  assign product = {11'b0, z_row[15:0]} * {16'b0, world_width};
  assign base    = product[15:0];

  // Tile numbers of this row; columns outside the window read zero.
  always_comb begin
    for (int c = 0; c < TILE_COLS; c++) begin
      if (c < EMIT_N) begin
        tiles_next[c] = base + xs[c][15:0];
      end else begin
        tiles_next[c] = '0;
      end
    end
  end

  // Row walker control.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      row    <= '0;
    end else if (load) begin
      active <= 1'b1;
      row    <= '0;
    end else if (advance) begin
      row <= row + ROW_W'(1);
      if (is_last) begin
        active <= 1'b0;
      end
    end
  end

  // Row walker payload.
  always_ff @(posedge clk) begin
    if (load) begin
      z_cur <= head.job.tz;
      xs    <= head.job.xs;
    end else if (advance) begin
      z_cur <= z_row + COORD_W'(1);
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rows.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_tiles <= tiles_next;
      out_row   <= row;
      out_last  <= is_last;
    end
  end

  assign rows.valid      = out_valid;
  assign rows.tile_0     = out_tiles[0];
  assign rows.tile_1     = out_tiles[1];
  assign rows.tile_2     = out_tiles[2];
  assign rows.tile_3     = out_tiles[3];
  assign rows.tile_4     = out_tiles[4];
  assign rows.tile_5     = out_tiles[5];
  assign rows.tile_6     = out_tiles[6];
  assign rows.tile_7     = out_tiles[7];
  assign rows.tile_8     = out_tiles[8];
  assign rows.row_number = out_row;
  assign rows.last_row   = out_last;

endmodule

### rtl/wrapped_tile_window_builder.sv
// Top level of the wrapped tile window builder: size registers, front part,
// job queue and back part. Depends on twb_pkg, twb_if, twb_front, twb_queue
// and twb_back.
//
// Usage: each word on items carries a world position and a map section
// origin. The block answers with a window of tile numbers, one word on rows
// per window row (min(WINDOW_SIZE, 9) rows), the last one flagged by
// last_row. World width and height are written through cfg_we, cfg_index
// and cfg_data while the block is idle; both reset to 64.
// A position word passes the start stage, column builder, job queue, row
// walker and output register; its later row words follow one per cycle
// while rows.ready is high; new position words are taken while earlier ones
// are still in flight. The rate is set by the column builder, one column
// coordinate per cycle, and by the row walker, one row word per cycle.
// Reset is synchronous and empties every stage and the queue.
// When the receiver holds rows.ready low, the row word waits in the output
// register, the row walker stops, the two-job queue fills and items.ready
// drops once the front part has nowhere to hand its work.
module wrapped_tile_window_builder #(
  parameter int WINDOW_SIZE = 9
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [twb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [twb_pkg::SIZE_W-1:0]     cfg_data,
  twb_in_if.sink                         items,
  twb_out_if.source                      rows
);
  import twb_pkg::*;

  size_t         world_width;
  size_t         world_height;
  twb_job_word_t push_word;
  twb_job_word_t head;
  logic          queue_full;
  logic          pop;

  // Size registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      world_width  <= SIZE_RESET;
      world_height <= SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WORLD_WIDTH:  world_width  <= cfg_data;
        REG_WORLD_HEIGHT: world_height <= cfg_data;
        default: ;
      endcase
    end
  end

  twb_front #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .items        (items),
    .world_width  (world_width),
    .world_height (world_height),
    .queue_full   (queue_full),
    .push_word    (push_word)
  );

  twb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_word (push_word),
    .full      (queue_full),
    .head      (head),
    .pop       (pop)
  );

  twb_back #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .pop          (pop),
    .world_width  (world_width),
    .world_height (world_height),
    .rows         (rows)
  );

endmodule

### test/tb_top.sv
// Self-checking bench for wrapped_tile_window_builder: drives position words, predicts
// every window row word and checks the rows that come back, across several map sizes.
// Depends on twb_pkg, twb_if and the RTL of the block.
module tb_top;
  import twb_pkg::*;

  localparam int ROWS       = 9;
  localparam int LONG_HOLD  = 200;
  localparam int LIMIT      = 400000;
  localparam int PHASES     = 10;
  localparam int PHASE_WORDS = 34;

  // One position word as offered to the block.
  typedef struct packed {
    logic signed [POS_W-1:0]    pos_x;
    logic signed [POS_W-1:0]    pos_z;
    logic signed [ORIGIN_W-1:0] origin_x;
    logic signed [ORIGIN_W-1:0] origin_z;
  } pos_word_t;

  // One window row word.
  typedef struct packed {
    tile_t [TILE_COLS-1:0] tiles;
    logic [ROW_W-1:0]      row_number;
    logic                  last_row;
  } row_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_WORLD_WIDTH;
  logic [SIZE_W-1:0] cfg_data = '0;

  twb_in_if  items_if ();
  twb_out_if rows_if ();

  wrapped_tile_window_builder #(.WINDOW_SIZE(ROWS)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .items     (items_if),
    .rows      (rows_if)
  );

  always #4 clk = ~clk;

  // Bench copy of the size registers, the queues and the handshake controls.
  size_t     cur_width  = SIZE_RESET;
  size_t     cur_height = SIZE_RESET;
  pos_word_t pending_words[$];
  row_word_t expected_rows[$];
  pos_word_t offered;
  int        error_count = 0;
  int        send_gap_left = 0;
  int        recv_wait_left = 0;
  int        hold_left = 0;
  int        holds_requested = 0;
  int        holds_served = 0;
  int        cycle_count = 0;
  bit        send_idle = 1'b1;
  bit        recv_idle = 1'b1;

  task automatic report_error(input string msg);
    $display("ERROR at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // Start tile along one axis: position down to a tile, into the map section,
  // one wrap against the section span, then drop the sub-tile bits.
  function automatic longint start_tile(input longint pos, input longint origin,
                                        input longint size);
    longint t;
    longint span;
    t = pos >>> 12;
    if (t < 0) t += 7;
    t = t >>> 3;
    t -= (origin + 2) * 256;
    span = size * 256;
    if (t < 0) begin
      t += span;
    end else if (span < t) begin
      t -= span;
    end
    return t >>> 8;
  endfunction

  // Expected row words of the window that one position word opens.
  task automatic predict_window(input pos_word_t w);
    longint wid;
    longint hgt;
    longint x0;
    longint x;
    longint z;
    longint base;
    row_word_t r;
    wid = cur_width;
    hgt = cur_height;
    x0  = start_tile(w.pos_x, w.origin_x, wid);
    z   = start_tile(w.pos_z, w.origin_z, hgt);
    for (int row = 0; row < ROWS; row++) begin
      if (!(z < hgt)) z = 0;
      base = z * wid;
      x = x0;
      for (int col = 0; col < TILE_COLS; col++) begin
        if (!(x < wid)) x = 0;
        r.tiles[col] = tile_t'(base + x);
        x++;
      end
      r.row_number = ROW_W'(row);
      r.last_row   = (row == ROWS - 1);
      z++;
      expected_rows.push_back(r);
    end
  endtask

  // Compare the row word on the output channel with the oldest expectation.
  task automatic check_row();
    row_word_t got;
    row_word_t want;
    got.tiles[0] = rows_if.tile_0;
    got.tiles[1] = rows_if.tile_1;
    got.tiles[2] = rows_if.tile_2;
    got.tiles[3] = rows_if.tile_3;
    got.tiles[4] = rows_if.tile_4;
    got.tiles[5] = rows_if.tile_5;
    got.tiles[6] = rows_if.tile_6;
    got.tiles[7] = rows_if.tile_7;
    got.tiles[8] = rows_if.tile_8;
    got.row_number = rows_if.row_number;
    got.last_row   = rows_if.last_row;
    if (expected_rows.size() == 0) begin
      report_error($sformatf("row word %0d with nothing expected", got.row_number));
      return;
    end
    want = expected_rows.pop_front();
    for (int c = 0; c < TILE_COLS; c++) begin
      if (got.tiles[c] !== want.tiles[c]) begin
        report_error($sformatf("row %0d tile_%0d got %0d expected %0d",
                               want.row_number, c, got.tiles[c], want.tiles[c]));
      end
    end
    if (got.row_number !== want.row_number) begin
      report_error($sformatf("row_number got %0d expected %0d",
                             got.row_number, want.row_number));
    end
    if (got.last_row !== want.last_row) begin
      report_error($sformatf("row %0d last_row got %0b expected %0b",
                             want.row_number, got.last_row, want.last_row));
    end
  endtask

  function automatic pos_word_t word_of(input logic signed [POS_W-1:0] px,
                                        input logic signed [POS_W-1:0] pz,
                                        input logic signed [ORIGIN_W-1:0] ox,
                                        input logic signed [ORIGIN_W-1:0] oz);
    pos_word_t w;
    w.pos_x    = px;
    w.pos_z    = pz;
    w.origin_x = ox;
    w.origin_z = oz;
    return w;
  endfunction

  // One axis that lands near the map section: the distance from the section
  // start is drawn around the span, with the exact wrap edges now and then.
  function automatic void shaped_axis(input longint size,
                                      output logic signed [POS_W-1:0] pos,
                                      output logic signed [ORIGIN_W-1:0] origin);
    logic signed [16:0] c17;
    logic [14:0] frac;
    longint cpos;
    longint rel;
    longint span;
    span = size * 256;
    c17  = 17'($urandom);
    frac = 15'($urandom);
    cpos = c17;
    case ($urandom_range(0, 9))
      0:       rel = -1;
      1:       rel = 0;
      2:       rel = span;
      3:       rel = span + 1;
      default: rel = longint'($urandom_range(0, 32'(span + 1024))) - 512;
    endcase
    // Line the position up so the section start falls on a whole tile.
    cpos = cpos - ((cpos - rel) & 255);
    if (cpos < -65536) cpos += 256;
    if (cpos < 0 && rel <= 0) frac[14:12] = '0;
    origin = ORIGIN_W'(((cpos - rel) >>> 8) - 2);
    pos    = {cpos[16:0], frac};
  endfunction

  // Mostly positions near the map, the rest raw noise.
  function automatic pos_word_t random_word(input size_t wid, input size_t hgt);
    pos_word_t w;
    if ($urandom_range(0, 9) < 3) begin
      w.pos_x    = $urandom;
      w.pos_z    = $urandom;
      w.origin_x = ORIGIN_W'($urandom);
      w.origin_z = ORIGIN_W'($urandom);
    end else begin
      shaped_axis(wid, w.pos_x, w.origin_x);
      shaped_axis(hgt, w.pos_z, w.origin_z);
    end
    return w;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input size_t value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_WORLD_WIDTH) begin
      cur_width = value;
    end else begin
      cur_height = value;
    end
  endtask

  // Wait until every word has been taken and every row word has come back.
  task automatic drain();
    do @(negedge clk);
    while (pending_words.size() != 0 || items_if.valid || expected_rows.size() != 0);
  endtask

  // Driver: offers pending words, with a drawn wait between words while send_idle is set.
  always @(posedge clk) begin
    if (rst) begin
      items_if.valid <= 1'b0;
      send_gap_left = 0;
    end else begin
      if (items_if.valid && items_if.ready) predict_window(offered);
      if (!items_if.valid || items_if.ready) begin
        if (send_gap_left > 0) begin
          send_gap_left--;
          items_if.valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          offered = pending_words.pop_front();
          items_if.valid    <= 1'b1;
          items_if.pos_x    <= offered.pos_x;
          items_if.pos_z    <= offered.pos_z;
          items_if.origin_x <= offered.origin_x;
          items_if.origin_z <= offered.origin_z;
          send_gap_left = send_idle ? $urandom_range(0, 5) : 0;
        end else begin
          items_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks accepted row words and stalls the output channel.
  always @(posedge clk) begin
    if (rst) begin
      rows_if.ready <= 1'b0;
      recv_wait_left = 0;
      hold_left = 0;
    end else begin
      if (rows_if.valid && rows_if.ready) begin
        check_row();
        recv_wait_left = recv_idle ? $urandom_range(0, 5) : 0;
      end
      if (holds_served != holds_requested) begin
        holds_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        rows_if.ready <= 1'b0;
      end else if (recv_wait_left > 0) begin
        recv_wait_left--;
        rows_if.ready <= 1'b0;
      end else begin
        rows_if.ready <= 1'b1;
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("wrapped_tile_window_builder test failed");
      $finish;
    end
  end

  initial begin
    size_t wid;
    size_t hgt;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed words at the reset sizes: field extremes, exact wrap edges,
    // rounding of negative positions, starts far off the map and windows
    // that wrap in both directions.
    @(negedge clk);
    pending_words.push_back(word_of(0, 0, 0, 0));
    pending_words.push_back(word_of(32'h7FFFFFFF, 32'h7FFFFFFF, 16'h7FFF, 16'h7FFF));
    pending_words.push_back(word_of(32'h80000000, 32'h80000000, 16'h8000, 16'h8000));
    pending_words.push_back(word_of(-32'sd1, -32'sd1, -16'sd1, -16'sd1));
    pending_words.push_back(word_of(32'h20000000, 32'h20008000, -16'sd2, -16'sd2));
    pending_words.push_back(word_of(32'hFFFF8000, 0, -16'sd2, -16'sd2));
    pending_words.push_back(word_of(32'h7FFFFFFF, 32'h80000000, -16'sd2, -16'sd2));
    pending_words.push_back(word_of(0, 0, 16'h7FFF, 16'h8000));
    pending_words.push_back(word_of(-32'sd4096, -32'sd4097, 0, 0));
    pending_words.push_back(word_of(32'hFFFF7FFF, 32'hFFFFF000, -16'sd2, -16'sd2));
    pending_words.push_back(word_of(32'h1F000000, 32'h1F800000, -16'sd2, -16'sd2));
    pending_words.push_back(word_of(32'h55555555, 32'hAAAAAAAA, 16'h5555, 16'hAAAA));
    pending_words.push_back(word_of(32'hAAAAAAAA, 32'h55555555, 16'hAAAA, 16'h5555));
    drain();

    // Random phases, each at its own map size, extremes first.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       begin wid = 1;    hgt = 1;    end
        1:       begin wid = 1024; hgt = 1024; end
        2:       begin wid = 0;    hgt = 0;    end
        3:       begin wid = 2047; hgt = 2047; end
        4:       begin wid = 3;    hgt = 1024; end
        5:       begin wid = 1024; hgt = 5;    end
        6:       begin
          wid = SIZE_W'($urandom_range(0, 2047));
          hgt = SIZE_W'($urandom_range(0, 2047));
        end
        default: begin
          wid = SIZE_W'($urandom_range(1, 1024));
          hgt = SIZE_W'($urandom_range(1, 1024));
        end
      endcase
      write_reg(REG_WORLD_WIDTH, wid);
      write_reg(REG_WORLD_HEIGHT, hgt);
      @(negedge clk);
      send_idle = (p % 3 != 1);
      recv_idle = (p % 4 != 2);
      // Hold the row channel off while words keep coming, so the block backs up.
      if (p == 4) begin
        send_idle = 1'b0;
        holds_requested++;
      end
      pending_words.push_back(word_of(0, 0, 0, 0));
      pending_words.push_back(word_of(32'h7FFFFFFF, 32'h80000000, 16'h7FFF, 16'h8000));
      for (int i = 0; i < PHASE_WORDS; i++) begin
        // Let the sender stop until the block has answered everything.
        if (p == 6 && i == PHASE_WORDS / 2) begin
          drain();
          send_idle = 1'b1;
        end
        pending_words.push_back(random_word(wid, hgt));
      end
      drain();
    end

    repeat (16) @(posedge clk);
    if (expected_rows.size() != 0) begin
      report_error($sformatf("%0d row words never arrived", expected_rows.size()));
    end
    if (error_count == 0) begin
      $display("wrapped_tile_window_builder test passed");
    end else begin
      $display("wrapped_tile_window_builder test failed");
    end
    $finish;
  end

endmodule

### wrapped_tile_window_builder.f
rtl/twb_pkg.sv
rtl/twb_if.sv
rtl/twb_front.sv
rtl/twb_queue.sv
rtl/twb_back.sv
rtl/wrapped_tile_window_builder.sv
test/tb_top.sv
